>>> src/are_pkg.sv
// ----------------------------------------------------------------------------
// are_pkg: shared types and constants for the attack/release envelope
// Transaction payloads, command codes, register indexes and derived widths.
// ----------------------------------------------------------------------------
package are_pkg;

    // Widths of the elapsed counter and of the level fraction
    localparam int ELAPSED_BITS    = 24;
    localparam int LEVEL_FRAC_BITS = 16;

    // Derived widths
    localparam int TICK_W  = 16;                        // ramp lengths, offset
    localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;       // Q1.FRAC level
    localparam int T_W     = ELAPSED_BITS + 1;          // elapsed + offset
    localparam int NUM_W   = LEVEL_W + TICK_W;          // product / dividend
    localparam int CNT_W   = $clog2(LEVEL_W + 1);       // serial step counter
    localparam int CMD_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE     = LEVEL_W'(1) << LEVEL_FRAC_BITS;
    localparam logic [TICK_W-1:0]  DEFAULT_TICKS = TICK_W'(80);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ATTACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PAUSE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS = 2'd1;

    // Input transaction
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TICK_W-1:0] offset;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               done_res;
    } out_item_t;

endpackage

>>> src/attack_release_envelope_top.sv
// ----------------------------------------------------------------------------
// attack_release_envelope_top: linear attack/release envelope generator
// Each command updates the timer state (a query only reads it) and returns one level/done result.
// ----------------------------------------------------------------------------
// One command is taken at a time. After acceptance the ST_SETUP state chooses
// the ramp case, then the block runs a bit-serial shift-add multiplier (release
// ramp only) and a bit-serial restoring divider (both ramps) before the result
// is loaded into the output register once that register is free. A command
// whose level is saturated (1.0 in attack, 0 in release) skips both serial
// units; s_ready rises again once the result sits in the output register.
// The user must write ramp lengths over the cfg port (always ready) only while
// no command is in flight; the block itself does not enforce this.
module attack_release_envelope_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // command channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  are_pkg::in_item_t                  s_data,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output are_pkg::out_item_t                 m_data,
    // configuration channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [are_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [are_pkg::TICK_W-1:0]         cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    localparam int ELAPSED_BITS = are_pkg::ELAPSED_BITS;
    localparam int TICK_W       = are_pkg::TICK_W;
    localparam int LEVEL_W      = are_pkg::LEVEL_W;
    localparam int T_W          = are_pkg::T_W;
    localparam int NUM_W        = are_pkg::NUM_W;
    localparam int CNT_W        = are_pkg::CNT_W;

    state_t                    state_reg,     state_next;
    logic [ELAPSED_BITS-1:0]   elapsed_reg,   elapsed_next;
    logic                      releasing_reg, releasing_next;
    logic                      held_reg,      held_next;
    logic                      started_reg,   started_next;
    logic [LEVEL_W-1:0]        rel_level_reg, rel_level_next;
    logic [TICK_W-1:0]         atk_ticks_reg, atk_ticks_next;
    logic [TICK_W-1:0]         rel_ticks_reg, rel_ticks_next;
    logic [T_W-1:0]            t_reg,         t_next;
    logic                      calc_rel_reg,  calc_rel_next;
    logic                      cap_reg,       cap_next;
    logic [NUM_W-1:0]          num_reg,       num_next;
    logic [TICK_W-1:0]         div_reg,       div_next;
    logic [CNT_W-1:0]          cnt_reg,       cnt_next;
    logic [LEVEL_W-1:0]        lvl_reg,       lvl_next;
    logic                      m_valid_reg,   m_valid_next;
    are_pkg::out_item_t        m_data_reg,    m_data_next;

    logic                      s_accept;
    logic                      out_free;
    logic [TICK_W:0]           trial;
    logic [TICK_W:0]           trial_diff;
    logic                      trial_ge;
    logic [LEVEL_W:0]          psum;
    logic                      done_flag;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // Divider step: restoring, one quotient bit per cycle
    assign trial      = {num_reg[NUM_W-1:LEVEL_W], num_reg[LEVEL_W-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign trial_ge   = (trial >= {1'b0, div_reg});

    // Multiplier step: LSB-first shift-add of the captured release level
    assign psum = {1'b0, num_reg[NUM_W-1:TICK_W]}
                + (num_reg[0] ? {1'b0, rel_level_reg} : {(LEVEL_W+1){1'b0}});

    // Done flag reflects the updated state, without the query offset
    assign done_flag = releasing_reg
                    && (elapsed_reg > ELAPSED_BITS'(rel_ticks_reg));

    // Next-state logic
    always_comb begin
        state_next     = state_reg;
        elapsed_next   = elapsed_reg;
        releasing_next = releasing_reg;
        held_next      = held_reg;
        started_next   = started_reg;
        rel_level_next = rel_level_reg;
        atk_ticks_next = atk_ticks_reg;
        rel_ticks_next = rel_ticks_reg;
        t_next         = t_reg;
        calc_rel_next  = calc_rel_reg;
        cap_next       = cap_reg;
        num_next       = num_reg;
        div_next       = div_reg;
        cnt_next       = cnt_reg;
        lvl_next       = lvl_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        // Result register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Configuration writes
        if (cfg_valid) begin
            if (cfg_index == are_pkg::REG_ATTACK_TICKS) begin
                atk_ticks_next = cfg_data;
            end else if (cfg_index == are_pkg::REG_RELEASE_TICKS) begin
                rel_ticks_next = cfg_data;
            end
        end

        case (state_reg)
            // Apply the command to the timer state, latch the evaluation time
            ST_IDLE: begin
                if (s_accept) begin
                    state_next    = ST_SETUP;
                    t_next        = T_W'(elapsed_reg);
                    calc_rel_next = releasing_reg;
                    cap_next      = 1'b0;
                    case (s_data.command)
                        are_pkg::CMD_TICK: begin
                            if (started_reg && !held_reg && (elapsed_reg != '1)) begin
                                elapsed_next = elapsed_reg + ELAPSED_BITS'(1);
                                t_next       = T_W'(elapsed_reg + ELAPSED_BITS'(1));
                            end
                        end
                        are_pkg::CMD_ATTACK: begin
                            releasing_next = 1'b0;
                            elapsed_next   = '0;
                            started_next   = 1'b1;
                            held_next      = 1'b0;
                            t_next         = '0;
                            calc_rel_next  = 1'b0;
                        end
                        are_pkg::CMD_RELEASE: begin
                            // level at the old time and old phase is captured
                            releasing_next = 1'b1;
                            elapsed_next   = '0;
                            started_next   = 1'b1;
                            held_next      = 1'b0;
                            cap_next       = 1'b1;
                        end
                        are_pkg::CMD_PAUSE: begin
                            held_next = 1'b1;
                        end
                        are_pkg::CMD_RESUME: begin
                            held_next = 1'b0;
                        end
                        are_pkg::CMD_QUERY: begin
                            t_next = T_W'(elapsed_reg) + T_W'(s_data.offset);
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Pick saturated level or start the serial datapath
            ST_SETUP: begin
                cnt_next = '0;
                if (calc_rel_reg) begin
                    div_next = rel_ticks_reg;
                    if (t_reg < T_W'(rel_ticks_reg)) begin
                        num_next   = {{LEVEL_W{1'b0}}, rel_ticks_reg - t_reg[TICK_W-1:0]};
                        state_next = ST_MUL;
                    end else begin
                        lvl_next   = '0;
                        state_next = ST_FIN;
                    end
                end else begin
                    div_next = atk_ticks_reg;
                    if (t_reg < T_W'(atk_ticks_reg)) begin
                        num_next   = NUM_W'({t_reg[TICK_W-1:0],
                                             {are_pkg::LEVEL_FRAC_BITS{1'b0}}});
                        state_next = ST_DIV;
                    end else begin
                        lvl_next   = are_pkg::LEVEL_ONE;
                        state_next = ST_FIN;
                    end
                end
            end

            // release_level * (release_ticks - t), one multiplier bit a cycle
            ST_MUL: begin
                num_next = {psum, num_reg[TICK_W-1:1]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TICK_W - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end

            // Quotient bits shift in at the bottom of num_reg
            ST_DIV: begin
                num_next = {(trial_ge ? trial_diff[TICK_W-1:0] : trial[TICK_W-1:0]),
                            num_reg[LEVEL_W-2:0], trial_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(LEVEL_W - 1)) begin
                    lvl_next   = {num_reg[LEVEL_W-2:0], trial_ge};
                    state_next = ST_FIN;
                end
            end

            // Load the result once the output register is free
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.done_res = done_flag;
                    m_data_next.level    = lvl_reg;
                    if (cap_reg) begin
                        // new release ramp at t = 0 gives the captured level
                        rel_level_next    = lvl_reg;
                        m_data_next.level = (rel_ticks_reg != '0) ? lvl_reg : '0;
                    end
                    cap_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            elapsed_reg   <= '0;
            releasing_reg <= 1'b0;
            held_reg      <= 1'b0;
            started_reg   <= 1'b0;
            rel_level_reg <= '0;
            atk_ticks_reg <= are_pkg::DEFAULT_TICKS;
            rel_ticks_reg <= are_pkg::DEFAULT_TICKS;
            calc_rel_reg  <= 1'b0;
            cap_reg       <= 1'b0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            elapsed_reg   <= elapsed_next;
            releasing_reg <= releasing_next;
            held_reg      <= held_next;
            started_reg   <= started_next;
            rel_level_reg <= rel_level_next;
            atk_ticks_reg <= atk_ticks_next;
            rel_ticks_reg <= rel_ticks_next;
            calc_rel_reg  <= calc_rel_next;
            cap_reg       <= cap_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
        end
        t_reg      <= t_next;
        num_reg    <= num_next;
        div_reg    <= div_next;
        lvl_reg    <= lvl_next;
        m_data_reg <= m_data_next;
    end

endmodule

>>> src/are_checker.sv
// ----------------------------------------------------------------------------
// are_checker: port-level checks for the attack/release envelope
// Watches the top level's transactions and flags illegal sequences.
// ----------------------------------------------------------------------------
module are_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  are_pkg::in_item_t              s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  are_pkg::out_item_t             m_data
);

    // A stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Level never exceeds 1.0
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.level <= are_pkg::LEVEL_ONE))
        else $error("level above 1.0");

    // A finished release always reports silence
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> (m_data.level == '0))
        else $error("done with nonzero level");

    // One command in flight: no acceptance right after another
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("back-to-back command acceptance");

endmodule

bind attack_release_envelope_top are_checker u_are_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
